>>> src/assert_macros.svh
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define BPC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bpc assertion failed");

// clocked assertion that also holds during reset
`define BPC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bpc assertion failed");

`endif

>>> src/bpc_pkg.sv
// types and constants of the button press classifier
// no dependencies
`timescale 1ns / 1ps

package bpc_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int ADDR_W        = 4;
	localparam int DATA_W        = 32;
	localparam int STAMP_W       = 32;
	localparam int CFG_W         = 16;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_LONG     = 2'd1;
	localparam logic [1:0] REG_WINDOW   = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;
	localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd300;

	localparam logic [1:0] TALLY_MAX = 2'd3;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} ev_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] long_hold_time;
		logic [CFG_W-1:0] double_window_time;
	} bpc_cfg_t;

endpackage

>>> src/bpc_ifs.sv
// valid/ready channel interfaces for samples and results
// no dependencies
`timescale 1ns / 1ps

interface bpc_sample_if;
	logic        valid;
	logic        ready;
	logic        pin_level;
	logic [31:0] now_ms;

	modport source (output valid, output pin_level, output now_ms, input ready);
	modport sink (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bpc_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] press_event;
	logic       is_down;

	modport source (output valid, output press_event, output is_down, input ready);
	modport sink (input valid, input press_event, input is_down, output ready);
endinterface

>>> src/bpc_cfg_regs.sv
// apb register file for the three timing registers
// depends on bpc_pkg
`timescale 1ns / 1ps

module bpc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpc_pkg::ADDR_W-1:0]  paddr,
	input  logic [bpc_pkg::DATA_W-1:0]  pwdata,
	output logic [bpc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output bpc_pkg::bpc_cfg_t           cfg
);
	import bpc_pkg::*;

	logic       wr_en;
	logic [1:0] reg_idx;
	bpc_cfg_t   cfg_q;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time      <= DEBOUNCE_RST;
			cfg_q.long_hold_time     <= LONG_RST;
			cfg_q.double_window_time <= WINDOW_RST;
		end else if (wr_en) begin
			// an index past the last register is dropped
			unique case (reg_idx)
				REG_DEBOUNCE: cfg_q.debounce_time      <= pwdata[CFG_W-1:0];
				REG_LONG:     cfg_q.long_hold_time     <= pwdata[CFG_W-1:0];
				REG_WINDOW:   cfg_q.double_window_time <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_DEBOUNCE: prdata[CFG_W-1:0] = cfg_q.debounce_time;
			REG_LONG:     prdata[CFG_W-1:0] = cfg_q.long_hold_time;
			REG_WINDOW:   prdata[CFG_W-1:0] = cfg_q.double_window_time;
			default:      prdata = '0;
		endcase
	end

endmodule

>>> src/bpc_core.sv
// debounce and press classification state, one sample per step
// depends on bpc_pkg
`timescale 1ns / 1ps

module bpc_core #(
	parameter int TIME_BITS = bpc_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bpc_pkg::bpc_cfg_t            cfg,
	input  logic                         step_en,
	input  logic                         pin_level,
	input  logic [bpc_pkg::STAMP_W-1:0]  now_ms,
	output bpc_pkg::ev_t                 press_event,
	output logic                         is_down
);
	import bpc_pkg::*;

	localparam int NB = (TIME_BITS < STAMP_W) ? TIME_BITS : STAMP_W;

	logic [TIME_BITS-1:0] now_w;

	logic                 raw_prev_q;
	logic                 stable_q;
	logic [TIME_BITS-1:0] change_stamp_q;
	logic [TIME_BITS-1:0] press_stamp_q;
	logic [TIME_BITS-1:0] release_stamp_q;
	logic [1:0]           tally_q;
	logic                 hold_q;
	logic                 await_q;

	logic                 raw;
	logic                 press_start;
	logic                 changed;
	logic [TIME_BITS-1:0] change_stamp_n;
	logic [TIME_BITS-1:0] press_stamp_n;
	logic [TIME_BITS-1:0] release_stamp_n;
	logic                 stable_n;
	logic [1:0]           tally_n;
	logic                 hold_n;
	logic                 await_n;
	logic [TIME_BITS-1:0] since_change;
	logic [TIME_BITS-1:0] since_press;
	logic [TIME_BITS-1:0] since_release;
	logic                 held_long;
	ev_t                  ev_n;

	always_comb begin
		now_w         = '0;
		now_w[NB-1:0] = now_ms[NB-1:0];
	end

	always_comb begin
		raw            = ~pin_level;
		press_start    = (raw != raw_prev_q) && raw && !stable_q;
		change_stamp_n = (raw != raw_prev_q) ? now_w : change_stamp_q;
		press_stamp_n  = press_start ? now_w : press_stamp_q;
		hold_n         = press_start ? 1'b0 : hold_q;

		since_change  = now_w - change_stamp_n;
		since_press   = now_w - press_stamp_n;
		held_long     = since_press >= TIME_BITS'(cfg.long_hold_time);
		changed       = (since_change >= TIME_BITS'(cfg.debounce_time)) && (raw != stable_q);
		stable_n      = changed ? raw : stable_q;

		tally_n         = tally_q;
		await_n         = await_q;
		release_stamp_n = release_stamp_q;
		ev_n            = EV_NONE;

		// debounced press edge, tally saturates
		if (changed && raw && (tally_q != TALLY_MAX)) begin
			tally_n = tally_q + 2'd1;
		end

		// debounced release edge
		if (changed && !raw) begin
			if (!hold_n && !held_long) begin
				release_stamp_n = now_w;
				if (tally_n[1]) begin
					ev_n    = EV_DOUBLE;
					tally_n = '0;
					await_n = 1'b0;
				end else begin
					await_n = 1'b1;
				end
			end else begin
				tally_n = '0;
				await_n = 1'b0;
			end
		end

		if (stable_n && !hold_n && held_long) begin
			hold_n  = 1'b1;
			tally_n = '0;
			await_n = 1'b0;
			ev_n    = EV_LONG;
		end

		// double-press window ran out
		since_release = now_w - release_stamp_n;
		if (await_n && !stable_n && (since_release >= TIME_BITS'(cfg.double_window_time))) begin
			await_n = 1'b0;
			tally_n = '0;
			ev_n    = EV_SINGLE;
		end
	end

	assign press_event = ev_n;
	assign is_down     = stable_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_prev_q      <= 1'b0;
			stable_q        <= 1'b0;
			change_stamp_q  <= '0;
			press_stamp_q   <= '0;
			release_stamp_q <= '0;
			tally_q         <= '0;
			hold_q          <= 1'b0;
			await_q         <= 1'b0;
		end else if (step_en) begin
			raw_prev_q      <= raw;
			stable_q        <= stable_n;
			change_stamp_q  <= change_stamp_n;
			press_stamp_q   <= press_stamp_n;
			release_stamp_q <= release_stamp_n;
			tally_q         <= tally_n;
			hold_q          <= hold_n;
			await_q         <= await_n;
		end
	end

endmodule

>>> src/button_press_classifier.sv
// top level of the button press classifier: channels, pipeline and apb port
// depends on bpc_pkg, bpc_ifs, bpc_cfg_regs and bpc_core
//
// usage: each sample word carries the raw active-low pin level and a
// millisecond time stamp; each sample gives exactly one result word with
// the press event (none, single, double, long hold) and the debounced state.
// samples enter through a valid/ready channel into an input register; the
// classification runs between that register and the result register.
// a sample leaves the input register when the result register is free or
// being emptied; one sample is taken every cycle while the result side keeps
// ready high, set by the single pass through the debounce and compare logic.
// when the receiver stalls the result word holds and one more sample may sit
// in the input register; sample ready then drops until the result is taken.
// the three timing registers sit at apb byte addresses 0, 4 and 8; the user
// writes them only while no sample is in flight; the block does not enforce.
// reset clears the channel valid flags, all press state (released, no
// pending press) and loads the timing registers with 50, 1000 and 300 ms.
`timescale 1ns / 1ps

module button_press_classifier #(
	parameter int TIME_BITS = bpc_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bpc_sample_if.sink                  sample,
	bpc_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpc_pkg::ADDR_W-1:0]  paddr,
	input  logic [bpc_pkg::DATA_W-1:0]  pwdata,
	output logic [bpc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import bpc_pkg::*;

	bpc_cfg_t             cfg;
	logic                 valid_s1;
	logic                 pin_s1;
	logic [STAMP_W-1:0]   now_s1;
	logic                 res_valid_q;
	ev_t                  res_event_q;
	logic                 res_down_q;
	logic                 advance;
	logic                 step;
	ev_t                  core_event;
	logic                 core_down;

	bpc_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bpc_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step_en     (step),
		.pin_level   (pin_s1),
		.now_ms      (now_s1),
		.press_event (core_event),
		.is_down     (core_down)
	);

	// result register free or being emptied this cycle
	assign advance      = !res_valid_q || result.ready;
	assign step         = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			pin_s1 <= sample.pin_level;
			now_s1 <= sample.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_event_q <= core_event;
			res_down_q  <= core_down;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.press_event = res_event_q;
	assign result.is_down     = res_down_q;

endmodule

>>> src/bpc_checker.sv
// port-level checks on the result channel, bound to the top level
// depends on bpc_pkg, assert_macros.svh and button_press_classifier
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       r_valid,
	input logic       r_ready,
	input logic [1:0] r_event,
	input logic       r_down
);
	import bpc_pkg::*;

	// a stalled word holds
	`BPC_ASSERT(a_stall_hold, clk, arst_n, r_valid && !r_ready |=> r_valid && $stable(r_event) && $stable(r_down))

	// long hold only while the button is down
	`BPC_ASSERT(a_long_down, clk, arst_n, r_valid && (r_event == EV_LONG) |-> r_down)

	// single and double presses are reported on or after release
	`BPC_ASSERT(a_click_up, clk, arst_n, r_valid && (r_event == EV_SINGLE || r_event == EV_DOUBLE) |-> !r_down)

	`BPC_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !r_valid)

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_event (result.press_event),
	.r_down  (result.is_down)
);

>>> tb/tb_top.sv
// self-checking bench for button_press_classifier: drives pin samples, predicts result words
// depends on bpc_pkg, bpc_ifs and the button_press_classifier rtl
`timescale 1ns / 1ps

module tb_top;
	import bpc_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_WORDS  = 1450;
	localparam int MAX_GAP       = 18;
	localparam int REPORT_LIMIT  = 10;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic [1:0] DOUBLE_COUNT = 2'd2;

	// idling styles for either side of the block
	localparam int IDLE_NONE = 0;
	localparam int IDLE_SOME = 1;
	localparam int IDLE_FULL = 2;

	typedef struct packed {
		logic        pin_level;
		logic [31:0] now_ms;
	} pin_sample_t;

	typedef struct packed {
		ev_t  press_event;
		logic is_down;
	} press_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	logic        drv_valid = 1'b0;
	logic        drv_pin = 1'b1;
	logic [31:0] drv_now = '0;
	logic        rcv_ready = 1'b0;

	bpc_sample_if sample_ch ();
	bpc_result_if result_ch ();

	assign sample_ch.valid     = drv_valid;
	assign sample_ch.pin_level = drv_pin;
	assign sample_ch.now_ms    = drv_now;
	assign result_ch.ready     = rcv_ready;

	button_press_classifier i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// timing register mirror, starts at the reset values
	logic [CFG_W-1:0] settle_span = DEBOUNCE_RST;
	logic [CFG_W-1:0] hold_span = LONG_RST;
	logic [CFG_W-1:0] window_ms = WINDOW_RST;

	// debounce and press classification state
	logic        deb_raw_prev = 1'b0;
	logic        deb_level = 1'b0;
	logic        deb_level_prev = 1'b0;
	logic [31:0] change_ms = '0;
	logic [31:0] press_ms = '0;
	logic [31:0] release_ms = '0;
	logic [1:0]  press_count = '0;
	logic        hold_flagged = 1'b0;
	logic        second_pending = 1'b0;

	pin_sample_t pending_samples[$];
	press_word_t expected_words[$];
	int words_queued = 0;
	int words_checked = 0;
	int fault_count = 0;
	int cycle_count = 0;

	int sender_idle = IDLE_FULL;
	int receiver_idle = IDLE_FULL;
	int send_gap = 0;
	int take_gap = 0;
	logic sample_taken = 1'b0;
	logic result_taken = 1'b0;

	logic [31:0] clock_ms = '0;
	int step_unit = 1;

	function automatic press_word_t classify_sample(input pin_sample_t s);
		logic        raw;
		logic        changed;
		logic [31:0] since_change;
		logic [31:0] since_press;
		logic [31:0] since_release;
		press_word_t w;
		raw = ~s.pin_level;
		changed = 1'b0;
		w.press_event = EV_NONE;
		if (raw != deb_raw_prev) begin
			change_ms = s.now_ms;
			if (raw && !deb_level) begin
				press_ms = s.now_ms;
				hold_flagged = 1'b0;
			end
			deb_raw_prev = raw;
		end
		since_change = s.now_ms - change_ms;
		if (since_change >= {16'd0, settle_span} && raw != deb_level) begin
			deb_level_prev = deb_level;
			deb_level = raw;
			changed = 1'b1;
		end
		if (changed && deb_level && !deb_level_prev && press_count != TALLY_MAX)
			press_count = press_count + 2'd1;
		since_press = s.now_ms - press_ms;
		if (changed && !deb_level && deb_level_prev) begin
			if (!hold_flagged && since_press < {16'd0, hold_span}) begin
				release_ms = s.now_ms;
				if (press_count >= DOUBLE_COUNT) begin
					w.press_event = EV_DOUBLE;
					press_count = '0;
					second_pending = 1'b0;
				end else begin
					second_pending = 1'b1;
				end
			end else begin
				// held too long: the press counts for nothing
				press_count = '0;
				second_pending = 1'b0;
			end
		end
		if (deb_level && !hold_flagged && since_press >= {16'd0, hold_span}) begin
			hold_flagged = 1'b1;
			press_count = '0;
			second_pending = 1'b0;
			w.press_event = EV_LONG;
		end
		since_release = s.now_ms - release_ms;
		if (second_pending && !deb_level && since_release >= {16'd0, window_ms}) begin
			second_pending = 1'b0;
			press_count = '0;
			w.press_event = EV_SINGLE;
		end
		deb_level_prev = deb_level;
		w.is_down = deb_level;
		return w;
	endfunction

	function automatic int draw_gap(input int style);
		case (style)
			IDLE_NONE: return 0;
			IDLE_SOME: return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, MAX_GAP);
			default: return $urandom_range(0, MAX_GAP);
		endcase
	endfunction

	function automatic void report_fault(input string what, input press_word_t want);
		fault_count++;
		if (fault_count <= REPORT_LIMIT)
			$display("%s: expected event %0d down %0b, got event %0d down %0b",
				what, want.press_event, want.is_down, result_ch.press_event, result_ch.is_down);
	endfunction

	// sample driver
	logic drv_up;
	pin_sample_t next_sample;

	always @(negedge clk) begin
		if (arst_n) begin
			drv_up = drv_valid;
			if (drv_valid && sample_taken) begin
				drv_up = 1'b0;
				send_gap = draw_gap(sender_idle);
			end
			if (!drv_up) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_samples.size() != 0) begin
					next_sample = pending_samples.pop_front();
					drv_pin <= next_sample.pin_level;
					drv_now <= next_sample.now_ms;
					drv_up = 1'b1;
				end
			end
			drv_valid <= drv_up;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (result_taken)
				take_gap = draw_gap(receiver_idle);
			if (take_gap > 0) begin
				take_gap--;
				rcv_ready <= 1'b0;
			end else begin
				rcv_ready <= 1'b1;
			end
		end
	end

	// monitor: checks result words, predicts on every accepted sample
	press_word_t want_word;
	pin_sample_t seen_sample;

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (result_ch.valid && rcv_ready) begin
				if (expected_words.size() == 0) begin
					want_word = '0;
					report_fault("unexpected result word", want_word);
				end else begin
					want_word = expected_words.pop_front();
					words_checked++;
					if (want_word.press_event !== result_ch.press_event ||
							want_word.is_down !== result_ch.is_down)
						report_fault("result mismatch", want_word);
				end
			end
			if (sample_ch.valid && sample_ch.ready) begin
				seen_sample.pin_level = sample_ch.pin_level;
				seen_sample.now_ms = sample_ch.now_ms;
				expected_words.push_back(classify_sample(seen_sample));
			end
			sample_taken <= sample_ch.valid && sample_ch.ready;
			result_taken <= result_ch.valid && rcv_ready;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic write_timing(input logic [1:0] index, input logic [CFG_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		// upper bits are junk, the block keeps only 16
		pwdata <= {16'($urandom()), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			REG_DEBOUNCE: settle_span = value;
			REG_LONG:     hold_span = value;
			REG_WINDOW:   window_ms = value;
			default: ;
		endcase
	endtask

	task automatic settle_pipeline();
		while (words_checked != words_queued)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic void queue_at(input logic pin, input logic [31:0] at_ms);
		pin_sample_t s;
		s.pin_level = pin;
		s.now_ms = at_ms;
		clock_ms = at_ms;
		pending_samples.push_back(s);
		words_queued++;
	endfunction

	function automatic void queue_after(input logic pin, input int dt);
		queue_at(pin, clock_ms + 32'(dt));
	endfunction

	function automatic int next_step();
		return ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, step_unit);
	endfunction

	// contact chatter that ends on the given level
	function automatic void chatter(input logic settle_level);
		int n;
		int deb;
		deb = int'(settle_span);
		n = $urandom_range(0, 3);
		repeat (n) begin
			queue_after(~settle_level, $urandom_range(0, deb / 2 + 1));
			queue_after(settle_level, $urandom_range(0, deb / 2 + 1));
		end
		queue_after(settle_level, $urandom_range(0, deb / 2 + 1));
	endfunction

	function automatic void press_gesture();
		int hold;
		int rest;
		int t;
		int dt;
		hold = $urandom_range(0, int'(hold_span) * 3 / 2 + int'(settle_span) + 2 * step_unit);
		rest = $urandom_range(0, 2 * int'(window_ms) + int'(settle_span) + 2 * step_unit);
		chatter(1'b0);
		t = 0;
		while (t < hold) begin
			dt = next_step();
			queue_after(1'b0, dt);
			t += dt;
		end
		chatter(1'b1);
		t = 0;
		while (t < rest) begin
			dt = next_step();
			queue_after(1'b1, dt);
			t += dt;
		end
	endfunction

	function automatic void pin_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) begin
			case ($urandom_range(0, 2))
				0: queue_after(1'($urandom_range(0, 1)), $urandom_range(0, 4 * step_unit));
				1: queue_at(1'($urandom_range(0, 1)), $urandom());
				default: queue_after(1'($urandom_range(0, 1)), 0);
			endcase
		end
	endfunction

	function automatic logic [CFG_W-1:0] pick_timing();
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(0, 16));
			1, 2: return 16'($urandom_range(0, 400));
			3: return 16'($urandom());
			default: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		endcase
	endfunction

	int phase_no;
	int phase_end;
	int widest;
	logic [CFG_W-1:0] new_debounce;
	logic [CFG_W-1:0] new_long;
	logic [CFG_W-1:0] new_window;

	initial begin
		// a real falling edge on reset clears the block before the first clock
		#1 arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words at the reset timings
		queue_at(1'b1, 32'd0);
		queue_at(1'b0, 32'd10);
		queue_at(1'b1, 32'd20);
		queue_at(1'b0, 32'd30);
		queue_at(1'b0, 32'd80);
		queue_at(1'b1, 32'd120);
		queue_at(1'b1, 32'd170);
		queue_at(1'b1, 32'd470);
		// double press
		queue_at(1'b0, 32'd500);
		queue_at(1'b0, 32'd550);
		queue_at(1'b1, 32'd600);
		queue_at(1'b1, 32'd650);
		queue_at(1'b0, 32'd700);
		queue_at(1'b0, 32'd750);
		queue_at(1'b1, 32'd800);
		queue_at(1'b1, 32'd850);
		// long hold, then a release that gives nothing
		queue_at(1'b0, 32'd900);
		queue_at(1'b0, 32'd950);
		queue_at(1'b0, 32'd1900);
		queue_at(1'b1, 32'd1950);
		queue_at(1'b1, 32'd2000);
		// press and release across the time wrap
		queue_at(1'b0, 32'hFFFF_FFE0);
		queue_at(1'b0, 32'h0000_0020);
		queue_at(1'b1, 32'hFFFF_FFFF);
		queue_at(1'b1, 32'h0000_0040);

		phase_no = 0;
		while (words_queued < RANDOM_WORDS + 25) begin
			settle_pipeline();
			case (phase_no)
				0: begin
					new_debounce = 16'h0000; new_long = 16'h0000; new_window = 16'h0000;
				end
				1: begin
					new_debounce = 16'hFFFF; new_long = 16'hFFFF; new_window = 16'hFFFF;
				end
				2: begin
					new_debounce = 16'h0000; new_long = 16'hFFFF; new_window = 16'h0000;
				end
				3: begin
					new_debounce = 16'd4; new_long = 16'd40; new_window = 16'd15;
				end
				default: begin
					new_debounce = pick_timing();
					new_long = pick_timing();
					new_window = pick_timing();
				end
			endcase
			write_timing(REG_DEBOUNCE, new_debounce);
			write_timing(REG_LONG, new_long);
			write_timing(REG_WINDOW, new_window);
			if (phase_no == 0 || $urandom_range(0, 3) == 0)
				write_timing(REG_UNUSED, 16'($urandom()));

			widest = int'(settle_span);
			if (int'(hold_span) > widest) widest = int'(hold_span);
			if (int'(window_ms) > widest) widest = int'(window_ms);
			step_unit = widest / 4 + 1;

			sender_idle = $urandom_range(IDLE_NONE, IDLE_FULL);
			receiver_idle = $urandom_range(IDLE_NONE, IDLE_FULL);
			if ($urandom_range(0, 3) == 0)
				clock_ms = 32'd0 - 32'($urandom_range(0, 200000));

			phase_end = words_queued + $urandom_range(60, 140);
			while (words_queued < phase_end) begin
				if ($urandom_range(0, 7) == 0)
					pin_noise();
				else
					press_gesture();
			end
			phase_no++;
		end

		settle_pipeline();
		if (fault_count == 0 && expected_words.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
